// ===== rtl/bssd_pkg.sv =====
package bssd_pkg;

    // Limits applied to the channel and sample registers
    localparam int unsigned CH_LIM      = 256;
    localparam int unsigned SP_LIM      = 65536;

    // Gain table geometry
    localparam int unsigned GAIN_DEPTH  = 256;
    localparam int unsigned GAIN_W      = 32;

    // Job queue between the front and back ends
    localparam int unsigned QDEPTH      = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef enum logic [1:0] {
        CFG_CHANNEL_COUNT      = 2'd0,
        CFG_SAMPLES_PER_RECORD = 2'd1,
        CFG_EXTRA_SENSOR_COUNT = 2'd2,
        CFG_WIDE_SAMPLES       = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_GAIN = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        CLASS_ELECTRODE = 2'd0,
        CLASS_EXTRA     = 2'd1,
        CLASS_STATUS    = 2'd2
    } class_t;

    typedef struct packed {
        logic [7:0]          channel_index;
        logic [15:0]         sample_in_record;
        logic signed [23:0]  raw_sample;
        class_t              channel_class;
        logic                last_of_record;
        logic signed [31:0]  gain;
    } job_t;

endpackage

// ===== rtl/bssd_ram.sv =====
module bssd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bssd_front.sv =====
module bssd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [1:0]                    cfg_addr,
    input  logic [16:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  bssd_pkg::req_t                req_type,
    input  logic [7:0]                    data_byte,
    input  logic [7:0]                    gain_channel,
    input  logic signed [31:0]            gain_value,
    input  logic [bssd_pkg::QCNT_W-1:0]   q_count,
    output logic                          push_valid,
    output bssd_pkg::job_t                push_job
);
    import bssd_pkg::*;

    logic [8:0]          chan_count_reg;
    logic [16:0]         samp_per_rec_reg;
    logic [7:0]          extra_reg;
    logic                wide_reg;

    logic [1:0]          phase_reg, phase_next;
    logic [7:0]          low_reg, low_next;
    logic [7:0]          mid_reg, mid_next;
    logic [15:0]         samp_cnt_reg, samp_cnt_next;
    logic [7:0]          chan_cnt_reg, chan_cnt_next;
    logic                job_vld_reg;
    job_t                job_reg, job_next;

    logic                s_fire, data_fire, gain_fire, sample_done;
    logic signed [23:0]  raw_w;
    logic [8:0]          nch;
    logic [16:0]         nsp;
    logic [8:0]          ch_inc;
    logic [16:0]         sp_inc;
    logic                last_ch, last_sp, electrode;
    logic signed [9:0]   elec_lim;
    logic [GAIN_W-1:0]   gain_rd;

    assign s_fire    = s_tvalid && s_tready;
    assign data_fire = s_fire && (req_type == REQ_DATA);
    assign gain_fire = s_fire && (req_type == REQ_GAIN);

    // Reserve a queue slot for the job in the read stage and one for this transfer
    assign s_tready = (q_count + QCNT_W'(job_vld_reg)) < QCNT_W'(QDEPTH);

    assign sample_done = data_fire && (wide_reg ? (phase_reg >= 2'd2) : (phase_reg != 2'd0));

    assign raw_w = wide_reg ? $signed({data_byte, mid_reg, low_reg})
                            : $signed({{8{data_byte[7]}}, data_byte, low_reg});

    always_comb begin
        if (chan_count_reg == 9'd0) begin
            nch = 9'd1;
        end else if (chan_count_reg > 9'(CH_LIM)) begin
            nch = 9'(CH_LIM);
        end else begin
            nch = chan_count_reg;
        end
        if (samp_per_rec_reg == 17'd0) begin
            nsp = 17'd1;
        end else if (samp_per_rec_reg > 17'(SP_LIM)) begin
            nsp = 17'(SP_LIM);
        end else begin
            nsp = samp_per_rec_reg;
        end
    end

    assign ch_inc    = {1'b0, chan_cnt_reg} + 9'd1;
    assign sp_inc    = {1'b0, samp_cnt_reg} + 17'd1;
    assign last_ch   = ch_inc >= nch;
    assign last_sp   = sp_inc >= nsp;
    assign elec_lim  = $signed({1'b0, nch}) - $signed({2'b00, extra_reg});
    assign electrode = $signed({1'b0, ch_inc}) < elec_lim;

    always_comb begin
        phase_next    = phase_reg;
        low_next      = low_reg;
        mid_next      = mid_reg;
        samp_cnt_next = samp_cnt_reg;
        chan_cnt_next = chan_cnt_reg;
        if (sample_done) begin
            phase_next = 2'd0;
            if (last_sp) begin
                samp_cnt_next = 16'd0;
                chan_cnt_next = last_ch ? 8'd0 : ch_inc[7:0];
            end else begin
                samp_cnt_next = sp_inc[15:0];
            end
        end else if (data_fire) begin
            if (phase_reg == 2'd0) begin
                low_next   = data_byte;
                phase_next = 2'd1;
            end else begin
                mid_next   = data_byte;
                phase_next = 2'd2;
            end
        end
    end

    always_comb begin
        job_next                  = job_reg;
        job_next.channel_index    = chan_cnt_reg;
        job_next.sample_in_record = samp_cnt_reg;
        job_next.raw_sample       = raw_w;
        job_next.last_of_record   = last_ch && last_sp;
        job_next.gain             = '0;
        if (last_ch) begin
            job_next.channel_class = CLASS_STATUS;
        end else if (electrode) begin
            job_next.channel_class = CLASS_ELECTRODE;
        end else begin
            job_next.channel_class = CLASS_EXTRA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg   <= 9'd1;
            samp_per_rec_reg <= 17'd1;
            extra_reg        <= 8'd0;
            wide_reg         <= 1'b1;
            phase_reg        <= 2'd0;
            low_reg          <= 8'd0;
            mid_reg          <= 8'd0;
            samp_cnt_reg     <= 16'd0;
            chan_cnt_reg     <= 8'd0;
            job_vld_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_CHANNEL_COUNT:      chan_count_reg   <= cfg_wdata[8:0];
                    CFG_SAMPLES_PER_RECORD: samp_per_rec_reg <= cfg_wdata;
                    CFG_EXTRA_SENSOR_COUNT: extra_reg        <= cfg_wdata[7:0];
                    CFG_WIDE_SAMPLES:       wide_reg         <= cfg_wdata[0];
                endcase
            end
            phase_reg    <= phase_next;
            low_reg      <= low_next;
            mid_reg      <= mid_next;
            samp_cnt_reg <= samp_cnt_next;
            chan_cnt_reg <= chan_cnt_next;
            job_vld_reg  <= sample_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_done) begin
            job_reg <= job_next;
        end
    end

    bssd_ram #(
        .WIDTH (GAIN_W),
        .DEPTH (GAIN_DEPTH)
    ) u_gain_ram (
        .aclk    (aclk),
        .wr_en   (gain_fire),
        .wr_addr (gain_channel),
        .wr_data (gain_value),
        .rd_en   (sample_done),
        .rd_addr (chan_cnt_reg),
        .rd_data (gain_rd)
    );

    always_comb begin
        push_job      = job_reg;
        push_job.gain = $signed(gain_rd);
    end
    assign push_valid = job_vld_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn) phase_reg != 2'd3)
        else $error("byte phase left its range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        sample_done |=> job_vld_reg)
        else $error("completed sample did not reach the read stage");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sample_done && !last_sp) |=> $stable(chan_cnt_reg))
        else $error("channel advanced inside a channel block");
`endif

endmodule

// ===== rtl/bssd_queue.sv =====
module bssd_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  bssd_pkg::job_t                push_job,
    input  logic                          pop,
    output logic                          head_valid,
    output bssd_pkg::job_t                head_job,
    output logic [bssd_pkg::QCNT_W-1:0]   count
);
    import bssd_pkg::*;

    job_t                mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != QCNT_W'(QDEPTH)) || pop)
        else $error("push into a full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from an empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue level past its depth");
`endif

endmodule

// ===== rtl/bssd_back.sv =====
module bssd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  bssd_pkg::job_t        q_job,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            channel_index,
    output logic [15:0]           sample_in_record,
    output logic signed [23:0]    raw_sample,
    output logic signed [55:0]    scaled_sample,
    output bssd_pkg::class_t      channel_class,
    output logic                  last_of_record
);
    import bssd_pkg::*;

    logic                a_vld_reg;
    job_t                a_job_reg;
    logic signed [55:0]  a_prod_reg, a_prod_next;
    logic                o_vld_reg;
    job_t                o_job_reg;
    logic signed [55:0]  o_prod_reg;
    logic                a_adv, o_adv;

    assign o_adv = !o_vld_reg || m_tready;
    assign a_adv = !a_vld_reg || o_adv;
    assign q_pop = q_valid && a_adv;

    // |raw * gain| stays within 2^54, so the 56-bit product never needs clamping
    always_comb begin
        if (q_job.channel_class == CLASS_STATUS) begin
            a_prod_next = 56'(q_job.raw_sample);
        end else begin
            a_prod_next = $signed(q_job.raw_sample) * $signed(q_job.gain);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            if (a_adv) begin
                a_vld_reg <= q_valid;
            end
            if (o_adv) begin
                o_vld_reg <= a_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_job_reg  <= q_job;
            a_prod_reg <= a_prod_next;
        end
        if (o_adv && a_vld_reg) begin
            o_job_reg  <= a_job_reg;
            o_prod_reg <= a_prod_reg;
        end
    end

    assign m_tvalid         = o_vld_reg;
    assign channel_index    = o_job_reg.channel_index;
    assign sample_in_record = o_job_reg.sample_in_record;
    assign raw_sample       = o_job_reg.raw_sample;
    assign scaled_sample    = o_prod_reg;
    assign channel_class    = o_job_reg.channel_class;
    assign last_of_record   = o_job_reg.last_of_record;

endmodule

// ===== rtl/bdf_sample_stream_decoder_top.sv =====
// BDF/EDF data-record decoder. Feed the record bytes one transfer at a time
// (s_tuser = 0); every third byte (24-bit mode) or second byte (16-bit mode)
// completes a little-endian sample, which comes out sign-extended together
// with its channel, its position in the channel block, its class and the
// product with the channel's signed Q8.24 gain. A transfer with s_tuser = 1
// writes one gain word and gives no result; the gain table holds no value
// until it is written. The last channel of a record is the status channel:
// it passes its raw value through unscaled. The block takes one transfer
// every cycle while s_tready is high. On its way a result passes the gain
// RAM's registered read, the four-entry job queue and the multiplier and
// output registers; s_tready drops only when the queue fills under output
// back-pressure. Write the configuration registers only while the block
// is idle.

module bdf_sample_stream_decoder_top (
    input  logic          aclk,
    input  logic          aresetn,

    // Configuration: 0 channel_count, 1 samples_per_record,
    // 2 extra_sensor_count, 3 wide_samples
    input  logic          cfg_wen,
    input  logic [1:0]    cfg_addr,
    input  logic [16:0]   cfg_wdata,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // data_byte[7:0], gain_channel[15:8], gain_value[47:16]
    input  logic [0:0]    s_tuser,   // req_type[0]

    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // channel_index[7:0], sample_in_record[23:8],
                                     // raw_sample[47:24], scaled_sample[103:48]
    output logic [1:0]    m_tuser,   // channel_class[1:0]
    output logic          m_tlast    // last_of_record
);
    import bssd_pkg::*;

    logic                push_valid;
    job_t                push_job;
    logic                head_valid;
    job_t                head_job;
    logic                q_pop;
    logic [QCNT_W-1:0]   q_count;

    logic [7:0]          channel_index;
    logic [15:0]         sample_in_record;
    logic signed [23:0]  raw_sample;
    logic signed [55:0]  scaled_sample;
    class_t              channel_class;

    // Front end: byte assembly, counters, classification and gain lookup
    bssd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req_type     (req_t'(s_tuser[0])),
        .data_byte    (s_tdata[7:0]),
        .gain_channel (s_tdata[15:8]),
        .gain_value   ($signed(s_tdata[47:16])),
        .q_count      (q_count),
        .push_valid   (push_valid),
        .push_job     (push_job)
    );

    // Hold completed samples so either side may stall on its own
    bssd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_job   (push_job),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    // Back end: gain multiply and output register
    bssd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (head_valid),
        .q_job            (head_job),
        .q_pop            (q_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .channel_index    (channel_index),
        .sample_in_record (sample_in_record),
        .raw_sample       (raw_sample),
        .scaled_sample    (scaled_sample),
        .channel_class    (channel_class),
        .last_of_record   (m_tlast)
    );

    // Pack the result transfer, first field lowest
    assign m_tdata = {scaled_sample, raw_sample, sample_in_record, channel_index};
    assign m_tuser = channel_class;

endmodule

// ===== bench/bdf_decode_checker.sv =====
`timescale 1ns / 1ps

module bdf_decode_checker (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          cfg_wen,
    input  logic [1:0]    cfg_addr,
    input  logic [16:0]   cfg_wdata,

    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [47:0]   s_tdata,   // data_byte[7:0], gain_channel[15:8], gain_value[47:16]
    input  logic [0:0]    s_tuser,   // req_type[0]

    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [103:0]  m_tdata,   // channel_index[7:0], sample_in_record[23:8],
                                     // raw_sample[47:24], scaled_sample[103:48]
    input  logic [1:0]    m_tuser,   // channel_class[1:0]
    input  logic          m_tlast,   // last_of_record

    output int            mismatch_count,
    output int            pending_count
);
    import bssd_pkg::*;

    localparam longint SCALED_MAX = 64'sh007F_FFFF_FFFF_FFFF;
    localparam longint SCALED_MIN = -SCALED_MAX - 1;

    typedef struct packed {
        logic [7:0]          channel;
        logic [15:0]         position;
        logic signed [23:0]  raw;
        logic signed [55:0]  scaled;
        class_t              kind;
        logic                last;
    } decoded_t;

    // Mirror of the register file
    logic [8:0]   ch_count_reg = 9'd1;
    logic [16:0]  spr_reg      = 17'd1;
    logic [7:0]   extra_reg    = 8'd0;
    logic         wide_reg     = 1'b1;

    // Byte assembly and record position
    logic [1:0]   byte_phase   = 2'd0;
    logic [7:0]   low_hold     = 8'd0;
    logic [7:0]   mid_hold     = 8'd0;
    logic [15:0]  sample_pos   = 16'd0;
    logic [7:0]   channel_pos  = 8'd0;
    logic [31:0]  gain_word [GAIN_DEPTH];

    decoded_t     pending_samples [$];
    int           errors = 0;

    task automatic decode_record_byte(input logic [7:0] b);
        logic signed [23:0] raw;
        logic signed [31:0] gain;
        longint             raw_l;
        longint             gain_l;
        longint             product;
        int                 nch;
        int                 nsp;
        bit                 last_ch;
        bit                 last_sp;
        decoded_t           want;
        if (byte_phase == 2'd0) begin
            low_hold   = b;
            byte_phase = 2'd1;
        end else if (wide_reg && byte_phase == 2'd1) begin
            mid_hold   = b;
            byte_phase = 2'd2;
        end else begin
            // narrow mode completes on any non-zero phase, low byte from the hold
            raw = wide_reg ? {b, mid_hold, low_hold} : {{8{b[7]}}, b, low_hold};
            byte_phase = 2'd0;

            nch = (ch_count_reg == 9'd0) ? 1 :
                  (int'(ch_count_reg) > int'(CH_LIM)) ? int'(CH_LIM) : int'(ch_count_reg);
            nsp = (spr_reg == 17'd0) ? 1 :
                  (int'(spr_reg) > int'(SP_LIM)) ? int'(SP_LIM) : int'(spr_reg);
            last_ch = (int'(channel_pos) + 1) >= nch;
            last_sp = (int'(sample_pos) + 1) >= nsp;

            want.channel  = channel_pos;
            want.position = sample_pos;
            want.raw      = raw;
            want.last     = last_ch && last_sp;
            if (last_ch) begin
                // status channel skips the gain
                want.kind   = CLASS_STATUS;
                want.scaled = raw;
            end else begin
                gain    = gain_word[channel_pos];
                raw_l   = raw;
                gain_l  = gain;
                product = raw_l * gain_l;
                if (product > SCALED_MAX) product = SCALED_MAX;
                if (product < SCALED_MIN) product = SCALED_MIN;
                want.scaled = product[55:0];
                want.kind   = (int'(channel_pos) + 1 < nch - int'(extra_reg)) ?
                              CLASS_ELECTRODE : CLASS_EXTRA;
            end
            pending_samples.push_back(want);

            if (last_sp) begin
                sample_pos  = 16'd0;
                channel_pos = last_ch ? 8'd0 : channel_pos + 8'd1;
            end else begin
                sample_pos  = sample_pos + 16'd1;
            end
        end
    endtask

    task automatic compare_result();
        decoded_t got;
        decoded_t want;
        got.channel  = m_tdata[7:0];
        got.position = m_tdata[23:8];
        got.raw      = m_tdata[47:24];
        got.scaled   = m_tdata[103:48];
        got.kind     = class_t'(m_tuser);
        got.last     = m_tlast;
        if (pending_samples.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: ch %0d pos %0d raw %0d scaled %0d",
                         got.channel, got.position, got.raw, got.scaled);
        end else begin
            want = pending_samples.pop_front();
            if (got.channel !== want.channel || got.position !== want.position ||
                got.raw !== want.raw || got.scaled !== want.scaled ||
                got.kind !== want.kind || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: ch %0d pos %0d raw %0d scaled %0d class %0d last %0b",
                             want.channel, want.position, want.raw, want.scaled,
                             want.kind, want.last);
                    $display("         got: ch %0d pos %0d raw %0d scaled %0d class %0d last %0b",
                             got.channel, got.position, got.raw, got.scaled,
                             got.kind, got.last);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ch_count_reg = 9'd1;
            spr_reg      = 17'd1;
            extra_reg    = 8'd0;
            wide_reg     = 1'b1;
            byte_phase   = 2'd0;
            low_hold     = 8'd0;
            mid_hold     = 8'd0;
            sample_pos   = 16'd0;
            channel_pos  = 8'd0;
            pending_samples.delete();
        end else begin
            // a transfer at this edge still sees the old register values
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == REQ_GAIN)
                    gain_word[s_tdata[15:8]] = s_tdata[47:16];
                else
                    decode_record_byte(s_tdata[7:0]);
            end
            if (m_tvalid && m_tready)
                compare_result();
            if (cfg_wen) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_CHANNEL_COUNT:      ch_count_reg = cfg_wdata[8:0];
                    CFG_SAMPLES_PER_RECORD: spr_reg      = cfg_wdata[16:0];
                    CFG_EXTRA_SENSOR_COUNT: extra_reg    = cfg_wdata[7:0];
                    CFG_WIDE_SAMPLES:       wide_reg     = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending_count  <= pending_samples.size();
        mismatch_count <= errors;
    end

endmodule

// ===== bench/tb_bdf_sample_stream_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_bdf_sample_stream_decoder_top;
    import bssd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASES      = 10;

    logic          aclk = 1'b0;
    logic          aresetn;

    logic          cfg_wen;
    logic [1:0]    cfg_addr;
    logic [16:0]   cfg_wdata;

    logic          s_tvalid;
    logic          s_tready;
    logic [47:0]   s_tdata;   // data_byte[7:0], gain_channel[15:8], gain_value[47:16]
    logic [0:0]    s_tuser;   // req_type[0]

    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [103:0]  m_tdata;   // channel_index[7:0], sample_in_record[23:8],
                              // raw_sample[47:24], scaled_sample[103:48]
    logic [1:0]    m_tuser;   // channel_class[1:0]
    logic          m_tlast;   // last_of_record

    int            mismatch_count;
    int            pending_count;

    // Sender burst state
    int            burst_left = 0;
    bit            no_gaps    = 1'b0;

    // Receiver stall state
    logic          hold_req   = 1'b0;
    logic          hold_done  = 1'b0;
    int            hold_left  = 0;
    int            ready_mode = 0;
    int            ready_run  = 0;

    int            cycle_count = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bdf_sample_stream_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    bdf_decode_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Watchdog: end the run as failed once the cycle counter reaches CYCLE_LIMIT
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: one long hold-off on request, otherwise segments of
    // always-ready, coin-toss and mostly-ready behaviour
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (ready_run == 0) begin
                ready_mode <= $urandom_range(0, 2);
                ready_run  <= $urandom_range(8, 48);
            end else begin
                ready_run  <= ready_run - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Offer one transfer and hold it until accepted. Open a new burst with a
    // random gap in front of it when the current one runs out.
    task automatic offer(input req_t kind, input logic [47:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Unused fields carry random bits so the block is seen to ignore them
    task automatic offer_byte(input logic [7:0] b);
        offer(REQ_DATA, {32'($urandom), 8'($urandom), b});
    endtask

    task automatic offer_gain(input logic [7:0] ch, input logic [31:0] gain);
        offer(REQ_GAIN, {gain, ch, 8'($urandom)});
    endtask

    task automatic offer_random(input bit allow_gain);
        logic [7:0]  b;
        logic [31:0] gain;
        if (allow_gain && $urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 3))
                0:       gain = 32'h7FFF_FFFF;
                1:       gain = 32'h8000_0000;
                default: gain = $urandom;
            endcase
            offer_gain(8'($urandom), gain);
        end else begin
            // bias towards the all-zeros and all-ones bytes for sign edges
            case ($urandom_range(0, 3))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            offer_byte(b);
        end
    endtask

    // Drop valid, wait for every expected result and let the pipeline settle
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write all four registers on consecutive edges; call only when idle
    task automatic set_config(input logic [16:0] cc, input logic [16:0] spr,
                              input logic [16:0] extra, input logic [16:0] wide);
        cfg_wen   <= 1'b1;
        cfg_addr  <= CFG_CHANNEL_COUNT;
        cfg_wdata <= cc;
        @(posedge aclk);
        cfg_addr  <= CFG_SAMPLES_PER_RECORD;
        cfg_wdata <= spr;
        @(posedge aclk);
        cfg_addr  <= CFG_EXTRA_SENSOR_COUNT;
        cfg_wdata <= extra;
        @(posedge aclk);
        cfg_addr  <= CFG_WIDE_SAMPLES;
        cfg_wdata <= wide;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        int n_items;

        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = CFG_CHANNEL_COUNT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_DATA;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole gain table first: an entry is never read unwritten
        for (int i = 0; i < GAIN_DEPTH; i++)
            offer_gain(8'(i), $urandom);
        drain();

        // Directed: three channels, two samples each; channel 0 electrode,
        // channel 1 extra sensor, channel 2 status
        set_config(17'd3, 17'd2, 17'd1, 17'd1);
        offer_gain(8'd0, 32'h7FFF_FFFF);
        offer_gain(8'd1, 32'h8000_0000);
        offer_byte(8'hFF); offer_byte(8'hFF); offer_byte(8'h7F);  // max times max gain
        offer_byte(8'h00); offer_byte(8'h00); offer_byte(8'h80);  // min times max gain
        offer_byte(8'h00); offer_byte(8'h00); offer_byte(8'h80);  // min times min gain
        offer_byte(8'hFF); offer_byte(8'hFF); offer_byte(8'hFF);  // minus one
        offer_byte(8'h01); offer_byte(8'h00); offer_byte(8'h00);  // status, no scaling
        // gain write mid-sample must leave the byte assembly alone
        offer_byte(8'h55);
        offer_gain(8'd2, 32'h0100_0000);
        offer_byte(8'hAA); offer_byte(8'h80);                    // end of record
        // switch to 16-bit mode with one byte held
        offer_byte(8'h34);
        drain();
        set_config(17'd3, 17'd2, 17'd1, 17'd0);
        offer_byte(8'hF0);
        offer_byte(8'h00); offer_byte(8'h80);                    // 16-bit minimum
        offer_byte(8'hFF); offer_byte(8'h7F);                    // 16-bit maximum
        drain();

        // Random phases; phase lengths are random so counters are often left
        // mid-record when the next setting lands
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(17'h1FF, 17'd0, 17'd255, 17'd0);   // clamps to 256 channels, 1 sample
                1: set_config(17'd256, 17'd1, 17'd0, 17'd1);
                2: set_config(17'd2, 17'd3, 17'd0, 17'd0);
                3: set_config(17'd3, 17'd2, 17'd0, 17'd0);      // back-pressure phase
                4: set_config(17'd0, 17'h1FFFF, 17'd0, 17'd1);   // one channel, clamped block
                5: set_config(17'd4, 17'h10000, 17'd3, 17'd0);
                6: set_config(17'd5, 17'd2, 17'd9, 17'd1);      // more extras than channels
                default: set_config(17'($urandom_range(1, 8)), 17'($urandom_range(1, 4)),
                                    17'($urandom_range(0, 8)), 17'($urandom_range(0, 1)));
            endcase

            if (p == 3) begin
                // Stall the output for a long stretch while bytes keep coming
                no_gaps  = 1'b1;
                hold_req <= 1'b1;
                for (int i = 0; i < 80; i++)
                    offer_random(1'b0);
                no_gaps  = 1'b0;
            end else begin
                n_items = $urandom_range(8, 16);
                for (int i = 0; i < n_items; i++)
                    offer_random(1'b1);
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
